// ----- rtl/assert_macros.svh -----
// Assertion shorthands for the codec modules.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A consequence that holds in the same cycle as its cause.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A consequence that holds in the cycle after its cause.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/b64c_pkg.sv -----
package b64c_pkg;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // Marks a character outside the alphabet.
  localparam logic [6:0] SEXTET_BAD = 7'd64;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       error;
  } res_t;

  // All results that one item causes, in order; last_idx is the count minus one.
  typedef struct packed {
    res_t [3:0] res;
    logic [1:0] last_idx;
    logic       last;
  } job_t;

  function automatic logic [7:0] to_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)       return w + 8'd65;
    else if (v < 6'd52)  return w + 8'd71;
    else if (v < 6'd62)  return w - 8'd4;
    else if (v == 6'd62) return CHAR_PLUS;
    else                 return CHAR_SLASH;
  endfunction

  function automatic logic [6:0] from_char(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A)      return 7'(c - 8'd65);
    else if (c >= 8'h61 && c <= 8'h7A) return 7'(c - 8'd71);
    else if (c >= 8'h30 && c <= 8'h39) return 7'(c + 8'd4);
    else if (c == CHAR_PLUS)           return 7'd62;
    else if (c == CHAR_SLASH)          return 7'd63;
    else                               return SEXTET_BAD;
  endfunction

endpackage

// ----- rtl/base64_stream_codec_top.sv -----
// Streaming base64 codec.
// Input channel: in_valid/in_stall with in_byte and in_last, one byte or character per item;
// in_last marks the final item of a message.
// Output channel: res_valid/res_stall with out_byte, out_valid, out_error and out_last.
// out_valid is 0 on error items and on the empty item that closes a message with no data.
// Configuration: cfg_valid/cfg_ready/cfg_data writes the mode bit (0 encode, 1 decode)
// and clears the pending bits; write it only while the codec is idle.
// An accepted item is written into the job queue; its first result then passes through the output
// register to the outputs.
// Throughput: the output register delivers one result per cycle while res_stall is low; an item
// has one to four results (four characters per three bytes when encoding).
// The input side classifies and takes one item per cycle as long as the job queue
// (QUEUE_DEPTH entries) has room; in_stall is high while the queue is full.
// When the receiver stalls, the output register holds its item and the queue fills,
// after which the input stalls too. Nothing is dropped.
// Reset selects encode mode, clears the pending bits, empties the queue and the
// output register.
module base64_stream_codec_top import b64c_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last,
  output logic       out_error
);

  logic push, pop, q_full, q_empty;
  job_t job_in, job_out;

  b64c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .q_full    (q_full),
    .push      (push),
    .job       (job_in)
  );

  b64c_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .job_in  (job_in),
    .pop     (pop),
    .job_out (job_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  b64c_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_job     (job_out),
    .q_empty   (q_empty),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .out_byte  (out_byte),
    .out_valid (out_valid),
    .out_last  (out_last),
    .out_error (out_error)
  );

endmodule

// ----- rtl/b64c_front.sv -----
module b64c_front import b64c_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       q_full,
  output logic       push,
  output job_t       job
);

  logic       mode;
  logic [5:0] store, store_next;
  logic [2:0] count, count_next;
  logic       dropping, dropping_next;
  logic       accept;
  res_t [3:0] r;
  logic [2:0] n;
  logic [11:0] s;
  logic [6:0] v;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    r             = '0;
    n             = 3'd0;
    s             = '0;
    v             = '0;
    store_next    = store;
    count_next    = count;
    dropping_next = dropping;
    if (mode == MODE_ENCODE) begin
      if (in_byte[7]) begin
        r[0].error = 1'b1;
        n          = 3'd1;
      end else begin
        s = {store[3:0], in_byte};
        unique case (count)
          3'd2: begin
            r[0]       = '{data: to_char(s[9:4]), valid: 1'b1, error: 1'b0};
            n          = 3'd1;
            store_next = {2'b00, s[3:0]};
            count_next = 3'd4;
          end
          3'd4: begin
            r[0]       = '{data: to_char(s[11:6]), valid: 1'b1, error: 1'b0};
            r[1]       = '{data: to_char(s[5:0]), valid: 1'b1, error: 1'b0};
            n          = 3'd2;
            store_next = '0;
            count_next = 3'd0;
          end
          default: begin
            r[0]       = '{data: to_char(s[7:2]), valid: 1'b1, error: 1'b0};
            n          = 3'd1;
            store_next = {4'b0000, s[1:0]};
            count_next = 3'd2;
          end
        endcase
      end
      // Flush the partial group and pad the message to a multiple of four.
      if (in_last) begin
        if (count_next == 3'd2) begin
          r[n[1:0]]          = '{data: to_char({store_next[1:0], 4'b0000}),
                                 valid: 1'b1, error: 1'b0};
          r[2'(n + 3'd1)]    = '{data: CHAR_PAD, valid: 1'b1, error: 1'b0};
          r[2'(n + 3'd2)]    = '{data: CHAR_PAD, valid: 1'b1, error: 1'b0};
          n                  = n + 3'd3;
        end else if (count_next == 3'd4) begin
          r[n[1:0]]          = '{data: to_char({store_next[3:0], 2'b00}),
                                 valid: 1'b1, error: 1'b0};
          r[2'(n + 3'd1)]    = '{data: CHAR_PAD, valid: 1'b1, error: 1'b0};
          n                  = n + 3'd2;
        end
      end
    end else if (!dropping && in_byte != CHAR_SPACE && in_byte != CHAR_PAD) begin
      v = from_char(in_byte);
      if (v == SEXTET_BAD) begin
        r[0].error    = 1'b1;
        n             = 3'd1;
        dropping_next = 1'b1;
      end else begin
        s = {store, v[5:0]};
        unique case (count)
          3'd2: begin
            r[0]       = '{data: s[7:0], valid: 1'b1, error: 1'b0};
            n          = 3'd1;
            store_next = '0;
            count_next = 3'd0;
          end
          3'd4: begin
            r[0]       = '{data: s[9:2], valid: 1'b1, error: 1'b0};
            n          = 3'd1;
            store_next = {4'b0000, s[1:0]};
            count_next = 3'd2;
          end
          3'd6: begin
            r[0]       = '{data: s[11:4], valid: 1'b1, error: 1'b0};
            n          = 3'd1;
            store_next = {2'b00, s[3:0]};
            count_next = 3'd4;
          end
          default: begin
            store_next = v[5:0];
            count_next = 3'd6;
          end
        endcase
      end
    end
    // A last item with nothing to send still closes the message with an empty item.
    if (in_last && n == 3'd0) begin
      n = 3'd1;
    end
    if (in_last) begin
      store_next    = '0;
      count_next    = '0;
      dropping_next = 1'b0;
    end
  end

  assign push         = accept && (n != 3'd0);
  assign job.res      = r;
  assign job.last_idx = 2'(n - 3'd1);
  assign job.last     = in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_ENCODE;
      store    <= '0;
      count    <= '0;
      dropping <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode     <= cfg_data;
      store    <= '0;
      count    <= '0;
      dropping <= 1'b0;
    end else if (accept) begin
      store    <= store_next;
      count    <= count_next;
      dropping <= dropping_next;
    end
  end

endmodule

// ----- rtl/b64c_queue.sv -----
`include "assert_macros.svh"

module b64c_queue import b64c_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t job_in,
  input  logic pop,
  output job_t job_out,
  output logic full,
  output logic empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign job_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_IMPLY(a_no_push_full, push, !full, "queue written while full")
  `ASSERT_IMPLY(a_no_pop_empty, pop, !empty, "queue read while empty")
  `ASSERT_NEXT(a_push_fills, push && !pop, !empty, "pushed item missing from queue")

endmodule

// ----- rtl/b64c_back.sv -----
`include "assert_macros.svh"

module b64c_back import b64c_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  job_t       q_job,
  input  logic       q_empty,
  output logic       pop,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_last,
  output logic       out_error
);

  logic [1:0] idx;
  logic       load;
  logic       at_end;
  res_t       sel;

  // The output register refills whenever the queue holds a job and the register is empty or its item is being taken.
  assign load   = !q_empty && (!res_valid || !res_stall);
  assign at_end = (idx == q_job.last_idx);
  assign sel    = q_job.res[idx];
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        idx       <= at_end ? '0 : idx + 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= sel.data;
      out_valid <= sel.valid;
      out_error <= sel.error;
      out_last  <= q_job.last && at_end;
    end
  end

  `ASSERT_IMPLY(a_idx_in_job, !q_empty, idx <= q_job.last_idx, "result index past end of job")
  `ASSERT_IMPLY(a_idx_idle, q_empty, idx == 2'd0, "result index left over with queue empty")
  `ASSERT_IMPLY(a_err_shape, res_valid && out_error, !out_valid && out_byte == 8'd0,
    "error item carries data")

endmodule
